FILE: src/i2c_ram_pkg.sv
// shared types and constants of the i2c register access master
package i2c_ram_pkg;

  // default width of the tick and attempt counters
  localparam int unsigned COUNT_WIDTH_DEFAULT = 16;

  // field widths
  localparam int unsigned DEV_ADDR_W = 7;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT       = 2'd2;

  // configuration reset values
  localparam logic [DEV_ADDR_W-1:0] DEVICE_ADDRESS_RESET    = 7'd81;
  localparam logic [CFG_DATA_W-1:0] HALF_PERIOD_TICKS_RESET = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] RETRY_LIMIT_RESET       = 16'd1000;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // one bus tick going in
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } i2c_ram_in_t;

  // line levels and status for one tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_enable;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       error;
    logic [7:0] read_data;
  } i2c_ram_out_t;

endpackage

FILE: src/i2c_register_access_master_unit.sv
// i2c master for one-byte register reads and writes, one bus tick per transfer
//
// Usage: every transfer on the input channel (in_valid/in_ready, in_data) is one tick
// of the bus sequencer and yields exactly one transfer on the output channel
// (out_valid/out_ready, out_data) carrying the SCL/SDA drive levels and status for
// that tick. A read or write command is taken only while no transaction runs; the
// transaction starts on that same tick. done_res marks the last tick, error with it
// reports that the device address was not acknowledged within the retry budget.
// out_valid rises in the cycle after the input transfer; throughput, while the receiver
// keeps up, is one tick per clock, set by the single output register between the state
// update and the output channel. When the receiver stalls, the result waits in the output
// register and in_ready drops until it is taken, so no tick is lost or repeated.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready: index 0
// device address, 1 half period in ticks, 2 retry limit; writes belong to idle time.
// Synchronous reset returns the sequencer to idle with SCL low and SDA released,
// clears the read byte and restores address 81, half period 1000, retry limit 1000.
module i2c_register_access_master_unit #(
  parameter int unsigned COUNT_WIDTH = i2c_ram_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  i2c_ram_pkg::i2c_ram_in_t               in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output i2c_ram_pkg::i2c_ram_out_t              out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [i2c_ram_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [i2c_ram_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned CMP_W = (COUNT_WIDTH + 1 > i2c_ram_pkg::CFG_DATA_W + 1) ?
                                  COUNT_WIDTH + 1 : i2c_ram_pkg::CFG_DATA_W + 1;
  localparam int unsigned ATT_W = (COUNT_WIDTH > i2c_ram_pkg::CFG_DATA_W) ?
                                  COUNT_WIDTH : i2c_ram_pkg::CFG_DATA_W;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST1, PH_ST2, PH_WH, PH_WL, PH_AK, PH_RH, PH_RL, PH_NK, PH_SP1, PH_SP2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_WADDR, KIND_REG, KIND_DATA, KIND_RADDR
  } kind_t;

  // configuration registers
  logic [i2c_ram_pkg::DEV_ADDR_W-1:0] device_address;
  logic [i2c_ram_pkg::CFG_DATA_W-1:0] half_period_ticks;
  logic [i2c_ram_pkg::CFG_DATA_W-1:0] retry_limit;

  // sequencer state
  phase_t                 phase, phase_next;
  kind_t                  kind, kind_next;
  logic [3:0]             bit_index, bit_index_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [COUNT_WIDTH-1:0] attempt_count, attempt_count_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic                   is_read, is_read_next;
  logic [7:0]             held_reg_addr, held_reg_addr_next;
  logic [7:0]             held_data, held_data_next;
  logic [7:0]             read_result, read_result_next;

  i2c_ram_pkg::i2c_ram_out_t result;
  logic                      in_xfer;
  logic                      seg_end;
  phase_t                    line_phase;
  logic                      line_bit;

  // line levels for each phase
  function automatic logic [2:0] lines_of(phase_t ph, logic b);
    logic [2:0] l;
    case (ph)
      PH_ST1:  l = 3'b011;
      PH_ST2:  l = 3'b110;
      PH_WH:   l = {2'b11, b};
      PH_WL:   l = {2'b01, b};
      PH_AK:   l = 3'b100;
      PH_RH:   l = 3'b100;
      PH_RL:   l = 3'b000;
      PH_NK:   l = 3'b111;
      PH_SP1:  l = 3'b010;
      PH_SP2:  l = 3'b111;
      default: l = 3'b000;
    endcase
    return l;
  endfunction

  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // next state for one tick
  always_comb begin
    phase_next         = phase;
    kind_next          = kind;
    bit_index_next     = bit_index;
    tick_count_next    = tick_count;
    attempt_count_next = attempt_count;
    shift_byte_next    = shift_byte;
    is_read_next       = is_read;
    held_reg_addr_next = held_reg_addr;
    held_data_next     = held_data;
    read_result_next   = read_result;
    result             = '0;
    seg_end            = 1'b0;

    // command start while idle
    if (phase == PH_IDLE &&
        (in_data.command == i2c_ram_pkg::CMD_READ ||
         in_data.command == i2c_ram_pkg::CMD_WRITE)) begin
      is_read_next       = (in_data.command == i2c_ram_pkg::CMD_READ);
      held_reg_addr_next = in_data.reg_addr;
      held_data_next     = in_data.write_data;
      attempt_count_next = '0;
      bit_index_next     = '0;
      kind_next          = KIND_WADDR;
      phase_next         = PH_ST1;
      tick_count_next    = '0;
    end

    line_phase = phase_next;
    line_bit   = shift_byte_next[7];
    {result.scl_level, result.sda_enable, result.sda_level} = lines_of(line_phase, line_bit);
    result.busy_res = (phase_next != PH_IDLE);

    if (phase_next != PH_IDLE) begin
      // read bits are sampled on the first tick of scl high
      if (phase_next == PH_RH && tick_count_next == '0) begin
        shift_byte_next = {shift_byte_next[6:0], in_data.sda_in};
      end
      seg_end = (CMP_W'(tick_count_next) + CMP_W'(1) >= CMP_W'(half_period_ticks)) ||
                (tick_count_next == '1);
      if (seg_end) begin
        tick_count_next = '0;
        case (phase_next)
          PH_ST1: phase_next = PH_ST2;
          PH_ST2: begin
            shift_byte_next = {device_address, kind_next == KIND_RADDR};
            bit_index_next  = '0;
            phase_next      = PH_WH;
          end
          PH_WH: phase_next = PH_WL;
          PH_WL: begin
            shift_byte_next = {shift_byte_next[6:0], 1'b0};
            bit_index_next  = bit_index_next + 4'd1;
            phase_next      = (bit_index_next < 4'd8) ? PH_WH : PH_AK;
          end
          PH_AK: begin
            if (kind_next == KIND_WADDR || kind_next == KIND_RADDR) begin
              if (ATT_W'(attempt_count_next) > ATT_W'(retry_limit)) begin
                // retries exhausted: end without stop
                result.done_res = 1'b1;
                result.error    = 1'b1;
                phase_next      = PH_IDLE;
              end else begin
                if (attempt_count_next != '1) begin
                  attempt_count_next = attempt_count_next + COUNT_WIDTH'(1);
                end
                if (in_data.sda_in) begin
                  phase_next = PH_ST1;
                end else if (kind_next == KIND_WADDR) begin
                  kind_next       = KIND_REG;
                  shift_byte_next = held_reg_addr_next;
                  bit_index_next  = '0;
                  phase_next      = PH_WH;
                end else begin
                  shift_byte_next = '0;
                  bit_index_next  = '0;
                  phase_next      = PH_RH;
                end
              end
            end else if (kind_next == KIND_REG) begin
              if (is_read_next) begin
                kind_next          = KIND_RADDR;
                attempt_count_next = '0;
                phase_next         = PH_ST1;
              end else begin
                kind_next       = KIND_DATA;
                shift_byte_next = held_data_next;
                bit_index_next  = '0;
                phase_next      = PH_WH;
              end
            end else begin
              phase_next = PH_SP1;
            end
          end
          PH_RH: phase_next = PH_RL;
          PH_RL: begin
            bit_index_next = bit_index_next + 4'd1;
            phase_next     = (bit_index_next < 4'd8) ? PH_RH : PH_NK;
          end
          PH_NK:  phase_next = PH_SP1;
          PH_SP1: phase_next = PH_SP2;
          PH_SP2: begin
            result.done_res = 1'b1;
            if (is_read_next) begin
              read_result_next = shift_byte_next;
            end
            phase_next = PH_IDLE;
          end
          default: phase_next = PH_IDLE;
        endcase
      end else begin
        tick_count_next = tick_count_next + COUNT_WIDTH'(1);
      end
    end

    result.read_data = read_result_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= i2c_ram_pkg::DEVICE_ADDRESS_RESET;
      half_period_ticks <= i2c_ram_pkg::HALF_PERIOD_TICKS_RESET;
      retry_limit       <= i2c_ram_pkg::RETRY_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        i2c_ram_pkg::CFG_DEVICE_ADDRESS:
          device_address <= cfg_data[i2c_ram_pkg::DEV_ADDR_W-1:0];
        i2c_ram_pkg::CFG_HALF_PERIOD_TICKS: half_period_ticks <= cfg_data;
        i2c_ram_pkg::CFG_RETRY_LIMIT:       retry_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      kind          <= KIND_WADDR;
      bit_index     <= '0;
      tick_count    <= '0;
      attempt_count <= '0;
      shift_byte    <= '0;
      is_read       <= 1'b0;
      held_reg_addr <= '0;
      held_data     <= '0;
      read_result   <= '0;
      out_valid     <= 1'b0;
    end else if (in_xfer) begin
      phase         <= phase_next;
      kind          <= kind_next;
      bit_index     <= bit_index_next;
      tick_count    <= tick_count_next;
      attempt_count <= attempt_count_next;
      shift_byte    <= shift_byte_next;
      is_read       <= is_read_next;
      held_reg_addr <= held_reg_addr_next;
      held_data     <= held_data_next;
      read_result   <= read_result_next;
      out_valid     <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data <= result;
    end
  end

  // checks
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> out_data.busy_res)
    else $error("done without busy");

  a_err_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error |-> out_data.done_res)
    else $error("error without done");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_count == '0)
    else $error("tick counter running while idle");

  a_xfer_out: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> out_valid)
    else $error("input transfer gave no result");

endmodule

FILE: test/tb_i2c_register_access_master_unit.sv
// testbench for the i2c register access master: every bus tick predicted and checked per transfer
module tb_i2c_register_access_master_unit;

  localparam int unsigned CNT_MAX        = (1 << i2c_ram_pkg::COUNT_WIDTH_DEFAULT) - 1;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned RANDOM_ITEMS   = 120;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned LONG_TICKS     = 20;

  // spare command code, handled as a plain tick
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef enum logic [3:0] {
    BP_IDLE, BP_START_A, BP_START_B, BP_BIT_HIGH, BP_BIT_LOW, BP_ACK,
    BP_READ_HIGH, BP_READ_LOW, BP_NAK, BP_STOP_A, BP_STOP_B
  } bus_phase_t;

  typedef enum logic [1:0] {BYTE_DEV_WR, BYTE_REG, BYTE_DATA, BYTE_DEV_RD} byte_kind_t;

  // block ports
  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               in_valid  = 1'b0;
  logic                               in_ready;
  i2c_ram_pkg::i2c_ram_in_t           in_data   = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  i2c_ram_pkg::i2c_ram_out_t          out_data;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [i2c_ram_pkg::CFG_IDX_W-1:0]  cfg_index = i2c_ram_pkg::CFG_DEVICE_ADDRESS;
  logic [i2c_ram_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  i2c_register_access_master_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // predicted sequencer state and settings
  logic [6:0]  dev_addr;
  int unsigned half_ticks;
  int unsigned retry_lim;
  bus_phase_t  bus_phase;
  byte_kind_t  cur_kind;
  logic [3:0]  bit_cnt;
  int unsigned tick_cnt;
  int unsigned attempts;
  logic [7:0]  shift_reg;
  logic        rd_mode;
  logic [7:0]  hold_reg;
  logic [7:0]  hold_data;
  logic        scl_q, sda_en_q, sda_q;
  logic [7:0]  rd_result;
  logic        fin_done, fin_err;

  // stimulus knobs and bookkeeping
  i2c_ram_pkg::i2c_ram_out_t expected_ticks[$];
  int unsigned  items_sent    = 0;
  int unsigned  snk_hold_len  = 0;
  int unsigned  pause_odds    = 0;
  int unsigned  idle_cycles   = 0;
  int           mismatch_count = 0;
  bit           src_gaps_on   = 1'b1;
  bit           snk_stalls_on = 1'b1;
  bit           noisy_acks    = 1'b0;

  function automatic void drive_lines(logic scl, logic en, logic lvl);
    scl_q    = scl;
    sda_en_q = en;
    sda_q    = en & lvl;
  endfunction

  // new bus segment: restart the tick counter and set the line levels
  function automatic void enter_phase(bus_phase_t p);
    logic msb;
    msb = shift_reg[7];
    bus_phase = p;
    tick_cnt = 0;
    case (p)
      BP_START_A:   drive_lines(1'b0, 1'b1, 1'b1);
      BP_START_B:   drive_lines(1'b1, 1'b1, 1'b0);
      BP_BIT_HIGH:  drive_lines(1'b1, 1'b1, msb);
      BP_BIT_LOW:   drive_lines(1'b0, 1'b1, msb);
      BP_ACK:       drive_lines(1'b1, 1'b0, 1'b0);
      BP_READ_HIGH: drive_lines(1'b1, 1'b0, 1'b0);
      BP_READ_LOW:  drive_lines(1'b0, 1'b0, 1'b0);
      BP_NAK:       drive_lines(1'b1, 1'b1, 1'b1);
      BP_STOP_A:    drive_lines(1'b0, 1'b1, 1'b0);
      BP_STOP_B:    drive_lines(1'b1, 1'b1, 1'b1);
      default: begin
        bus_phase = BP_IDLE;
        drive_lines(1'b0, 1'b0, 1'b0);
      end
    endcase
  endfunction

  function automatic void load_byte(byte_kind_t kind, logic [7:0] value);
    cur_kind = kind;
    shift_reg = value;
    bit_cnt = '0;
    enter_phase(BP_BIT_HIGH);
  endfunction

  function automatic void end_transaction(logic err);
    fin_done = 1'b1;
    fin_err = err;
    if (!err && rd_mode) rd_result = shift_reg;
    enter_phase(BP_IDLE);
  endfunction

  // only device address acknowledges are honored, the attempt budget is checked first
  function automatic void resolve_ack(logic nak);
    if (cur_kind == BYTE_DEV_WR || cur_kind == BYTE_DEV_RD) begin
      if (attempts > retry_lim) begin
        end_transaction(1'b1);
      end else begin
        if (attempts < CNT_MAX) attempts++;
        if (nak) begin
          enter_phase(BP_START_A);
        end else if (cur_kind == BYTE_DEV_WR) begin
          load_byte(BYTE_REG, hold_reg);
        end else begin
          shift_reg = '0;
          bit_cnt = '0;
          enter_phase(BP_READ_HIGH);
        end
      end
    end else if (cur_kind == BYTE_REG) begin
      if (rd_mode) begin
        cur_kind = BYTE_DEV_RD;
        attempts = 0;
        enter_phase(BP_START_A);
      end else begin
        load_byte(BYTE_DATA, hold_data);
      end
    end else begin
      enter_phase(BP_STOP_A);
    end
  endfunction

  function automatic void end_segment(logic sda);
    case (bus_phase)
      BP_START_A:  enter_phase(BP_START_B);
      BP_START_B:  load_byte(cur_kind, {dev_addr, cur_kind == BYTE_DEV_RD});
      BP_BIT_HIGH: enter_phase(BP_BIT_LOW);
      BP_BIT_LOW: begin
        shift_reg = shift_reg << 1;
        bit_cnt = bit_cnt + 4'd1;
        enter_phase(bit_cnt < 4'd8 ? BP_BIT_HIGH : BP_ACK);
      end
      BP_ACK:       resolve_ack(sda);
      BP_READ_HIGH: enter_phase(BP_READ_LOW);
      BP_READ_LOW: begin
        bit_cnt = bit_cnt + 4'd1;
        enter_phase(bit_cnt < 4'd8 ? BP_READ_HIGH : BP_NAK);
      end
      BP_NAK:    enter_phase(BP_STOP_A);
      BP_STOP_A: enter_phase(BP_STOP_B);
      BP_STOP_B: end_transaction(1'b0);
      default:   enter_phase(BP_IDLE);
    endcase
  endfunction

  function automatic void reset_model();
    dev_addr = i2c_ram_pkg::DEVICE_ADDRESS_RESET;
    half_ticks = 32'(i2c_ram_pkg::HALF_PERIOD_TICKS_RESET);
    retry_lim = 32'(i2c_ram_pkg::RETRY_LIMIT_RESET);
    bit_cnt = '0;
    attempts = 0;
    shift_reg = '0;
    rd_mode = 1'b0;
    hold_reg = '0;
    hold_data = '0;
    rd_result = '0;
    cur_kind = BYTE_DEV_WR;
    enter_phase(BP_IDLE);
  endfunction

  function automatic void apply_config(logic [i2c_ram_pkg::CFG_IDX_W-1:0] idx,
                                       logic [i2c_ram_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      i2c_ram_pkg::CFG_DEVICE_ADDRESS:    dev_addr = value[i2c_ram_pkg::DEV_ADDR_W-1:0];
      i2c_ram_pkg::CFG_HALF_PERIOD_TICKS: half_ticks = 32'(value);
      i2c_ram_pkg::CFG_RETRY_LIMIT:       retry_lim = 32'(value);
      default: ;
    endcase
  endfunction

  // line levels and status expected for one bus tick
  function automatic i2c_ram_pkg::i2c_ram_out_t next_bus_tick(i2c_ram_pkg::i2c_ram_in_t t);
    i2c_ram_pkg::i2c_ram_out_t r;
    logic busy;
    fin_done = 1'b0;
    fin_err = 1'b0;
    if (bus_phase == BP_IDLE &&
        (t.command == i2c_ram_pkg::CMD_READ || t.command == i2c_ram_pkg::CMD_WRITE)) begin
      rd_mode = (t.command == i2c_ram_pkg::CMD_READ);
      hold_reg = t.reg_addr;
      hold_data = t.write_data;
      attempts = 0;
      bit_cnt = '0;
      cur_kind = BYTE_DEV_WR;
      enter_phase(BP_START_A);
    end
    busy = (bus_phase != BP_IDLE);
    r.scl_level = scl_q;
    r.sda_enable = sda_en_q;
    r.sda_level = sda_q;
    r.busy_res = busy;
    if (busy) begin
      if (bus_phase == BP_READ_HIGH && tick_cnt == 0) shift_reg = {shift_reg[6:0], t.sda_in};
      if (tick_cnt + 1 >= half_ticks || tick_cnt >= CNT_MAX) end_segment(t.sda_in);
      else tick_cnt++;
    end
    r.done_res = fin_done;
    r.error = fin_err;
    r.read_data = rd_result;
    return r;
  endfunction

  // stop offering ticks until every outstanding result is in
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_ticks.size() != 0);
  endtask

  // one tick transfer on the input side, prediction at acceptance
  task automatic send_tick(i2c_ram_pkg::i2c_ram_in_t t);
    int unsigned gap;
    gap = src_gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    expected_ticks.push_back(next_bus_tick(t));
    items_sent++;
    if (pause_odds != 0 && $urandom_range(0, 999) < pause_odds) wait_for_results();
  endtask

  task automatic idle_ticks(int unsigned n);
    i2c_ram_pkg::i2c_ram_in_t t;
    repeat (n) begin
      t.command = $urandom_range(0, 1) ? CMD_SPARE : i2c_ram_pkg::CMD_TICK;
      t.reg_addr = 8'($urandom);
      t.write_data = 8'($urandom);
      t.sda_in = 1'($urandom_range(0, 1));
      send_tick(t);
    end
  endtask

  // one transaction from command to done, the device answering per the arguments
  task automatic run_txn(logic [1:0] cmd, logic [7:0] reg_byte, logic [7:0] data_byte,
                         int unsigned wr_naks, int unsigned rd_naks, logic [7:0] rd_byte);
    i2c_ram_pkg::i2c_ram_in_t t;
    logic        addr_ack;
    byte_kind_t  kind_sent;
    t.command = cmd;
    t.reg_addr = reg_byte;
    t.write_data = data_byte;
    t.sda_in = 1'($urandom_range(0, 1));
    send_tick(t);
    while (bus_phase != BP_IDLE) begin
      t.command = 2'($urandom_range(0, 3));
      t.reg_addr = 8'($urandom);
      t.write_data = 8'($urandom);
      addr_ack = (bus_phase == BP_ACK) && (cur_kind == BYTE_DEV_WR || cur_kind == BYTE_DEV_RD);
      kind_sent = cur_kind;
      if (addr_ack && !noisy_acks)
        t.sda_in = (kind_sent == BYTE_DEV_WR) ? (wr_naks != 0) : (rd_naks != 0);
      else if (bus_phase == BP_READ_HIGH && !noisy_acks)
        t.sda_in = rd_byte[3'd7 - bit_cnt[2:0]];
      else
        t.sda_in = 1'($urandom_range(0, 1));
      send_tick(t);
      // one refusal used up once the acknowledge was taken
      if (addr_ack && bus_phase != BP_ACK && t.sda_in) begin
        if (kind_sent == BYTE_DEV_WR && wr_naks != 0) wr_naks--;
        else if (kind_sent == BYTE_DEV_RD && rd_naks != 0) rd_naks--;
      end
    end
  endtask

  // run the sequencer back to idle and let every result arrive
  task automatic settle_bus();
    i2c_ram_pkg::i2c_ram_in_t t;
    while (bus_phase != BP_IDLE) begin
      t.command = i2c_ram_pkg::CMD_TICK;
      t.reg_addr = 8'($urandom);
      t.write_data = 8'($urandom);
      t.sda_in = 1'b0;
      send_tick(t);
    end
    wait_for_results();
  endtask

  task automatic write_config(logic [i2c_ram_pkg::CFG_IDX_W-1:0] idx,
                              logic [i2c_ram_pkg::CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_config(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [6:0] dev, logic [15:0] half, logic [15:0] retry);
    settle_bus();
    write_config(i2c_ram_pkg::CFG_DEVICE_ADDRESS, {9'd0, dev});
    write_config(i2c_ram_pkg::CFG_HALF_PERIOD_TICKS, half);
    write_config(i2c_ram_pkg::CFG_RETRY_LIMIT, retry);
  endtask

  function automatic int unsigned draw_refusals();
    return ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
  endfunction

  // idle after reset: SCL low, SDA released and the cleared read byte on the outputs
  task automatic test_idle_ticks();
    idle_ticks(6);
  endtask

  // write at reset address, extreme register and data bytes
  task automatic test_register_write();
    settle_bus();
    write_config(i2c_ram_pkg::CFG_HALF_PERIOD_TICKS, 16'd1);
    run_txn(i2c_ram_pkg::CMD_WRITE, 8'h00, 8'hFF, 0, 0, 8'h00);
  endtask

  task automatic test_register_read();
    run_txn(i2c_ram_pkg::CMD_READ, 8'h5A, 8'h00, 0, 0, 8'hFF);
    idle_ticks(2);
    run_txn(i2c_ram_pkg::CMD_READ, 8'h3C, 8'hC3, 0, 0, 8'hA5);
  endtask

  task automatic test_address_extremes();
    configure(7'd0, 16'd1, i2c_ram_pkg::RETRY_LIMIT_RESET);
    run_txn(i2c_ram_pkg::CMD_WRITE, 8'h81, 8'h7E, 0, 0, 8'h00);
    configure(7'd127, 16'd1, i2c_ram_pkg::RETRY_LIMIT_RESET);
    run_txn(i2c_ram_pkg::CMD_READ, 8'hE7, 8'h00, 0, 0, 8'h69);
  endtask

  // a zero half period acts as one tick
  task automatic test_half_period_zero();
    configure(7'd81, 16'd0, i2c_ram_pkg::RETRY_LIMIT_RESET);
    run_txn(i2c_ram_pkg::CMD_WRITE, 8'h12, 8'h34, 0, 0, 8'h00);
  endtask

  // refused device addresses repeat start and address
  task automatic test_address_retry();
    configure(7'd44, 16'd1, 16'd1000);
    run_txn(i2c_ram_pkg::CMD_WRITE, 8'h0F, 8'hF0, 1, 0, 8'h00);
    run_txn(i2c_ram_pkg::CMD_READ, 8'hF0, 8'h00, 1, 1, 8'h5C);
  endtask

  // attempt budget spent: error end without stop, read byte kept
  task automatic test_retry_exhausted();
    configure(7'd81, 16'd1, 16'd0);
    run_txn(i2c_ram_pkg::CMD_WRITE, 8'h01, 8'h02, 1, 0, 8'h00);
    run_txn(i2c_ram_pkg::CMD_READ, 8'h04, 8'h00, 0, 1, 8'h39);
    configure(7'd81, 16'd1, 16'd1);
    run_txn(i2c_ram_pkg::CMD_WRITE, 8'h05, 8'h06, 2, 0, 8'h00);
  endtask

  // largest budget keeps retrying until the device answers
  task automatic test_retry_unbounded();
    configure(7'd100, 16'd1, 16'hFFFF);
    run_txn(i2c_ram_pkg::CMD_WRITE, 8'h77, 8'h88, 2, 0, 8'h00);
  endtask

  // long receiver hold while ticks keep coming
  task automatic test_backpressure();
    src_gaps_on = 1'b0;
    snk_hold_len = HOLD_CYCLES;
    run_txn(i2c_ram_pkg::CMD_WRITE, 8'($urandom), 8'($urandom), 0, 0, 8'h00);
    src_gaps_on = 1'b1;
  endtask

  // sender pauses mid-transaction until all results are in
  task automatic test_drain_pause();
    pause_odds = 100;
    run_txn(i2c_ram_pkg::CMD_READ, 8'($urandom), 8'($urandom), 0, 0, 8'($urandom));
    pause_odds = 0;
    idle_ticks(3);
    wait_for_results();
    idle_ticks(2);
  endtask

  // random transactions over several settings
  task automatic test_random_traffic();
    int unsigned start_items;
    logic [6:0]  dev;
    logic [15:0] half;
    logic [15:0] retry;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin dev = 7'd0;   half = 16'd1; retry = 16'd0;    end
        1: begin dev = 7'd127; half = 16'd2; retry = 16'hFFFF; end
        2: begin dev = 7'($urandom); half = 16'd0; retry = 16'd1;  end
        3: begin dev = 7'($urandom); half = 16'd1; retry = 16'd2;  end
        4: begin dev = 7'($urandom); half = 16'd3; retry = 16'd3;  end
        default: begin
          dev = 7'($urandom);
          half = 16'($urandom_range(1, 4));
          retry = 16'($urandom_range(0, 4));
        end
      endcase
      configure(dev, half, retry);
      start_items = items_sent;
      pause_odds = 3;
      while (items_sent < start_items + RANDOM_ITEMS / RANDOM_PHASES) begin
        src_gaps_on = ($urandom_range(0, 3) != 0);
        snk_stalls_on = ($urandom_range(0, 3) != 0);
        noisy_acks = ($urandom_range(0, 9) == 0);
        idle_ticks($urandom_range(0, 4));
        run_txn($urandom_range(0, 1) ? i2c_ram_pkg::CMD_READ : i2c_ram_pkg::CMD_WRITE,
                8'($urandom), 8'($urandom), draw_refusals(), draw_refusals(), 8'($urandom));
      end
      pause_odds = 0;
      noisy_acks = 1'b0;
    end
    src_gaps_on = 1'b1;
    snk_stalls_on = 1'b1;
  endtask

  // largest half period: the transaction stays in its first segment
  task automatic test_long_half_period();
    i2c_ram_pkg::i2c_ram_in_t t;
    configure(7'($urandom), 16'hFFFF, 16'($urandom));
    src_gaps_on = 1'b0;
    t.command = i2c_ram_pkg::CMD_WRITE;
    t.reg_addr = 8'($urandom);
    t.write_data = 8'($urandom);
    t.sda_in = 1'($urandom_range(0, 1));
    send_tick(t);
    repeat (LONG_TICKS) begin
      t.command = 2'($urandom_range(0, 3));
      t.reg_addr = 8'($urandom);
      t.write_data = 8'($urandom);
      t.sda_in = 1'($urandom_range(0, 1));
      send_tick(t);
    end
  endtask

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // result side: random stalls, one long hold on request, check per transfer
  initial begin
    int unsigned  stall;
    i2c_ram_pkg::i2c_ram_out_t want;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (snk_hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (snk_hold_len) @(posedge clk);
        snk_hold_len = 0;
      end else begin
        stall = snk_stalls_on ? $urandom_range(0, 13) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_ticks.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no tick outstanding, expected none, actual %h",
                 $time, out_data);
      end else begin
        want = expected_ticks.pop_front();
        compare_field("scl_level", 8'(want.scl_level), 8'(out_data.scl_level));
        compare_field("sda_enable", 8'(want.sda_enable), 8'(out_data.sda_enable));
        compare_field("sda_level", 8'(want.sda_level), 8'(out_data.sda_level));
        compare_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
        compare_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
        compare_field("error", 8'(want.error), 8'(out_data.error));
        compare_field("read_data", want.read_data, out_data.read_data);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_i2c_register_access_master_unit failed");
        $finish;
      end
    end
  end

  // reset, test sequence and verdict
  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_ticks();
    test_register_write();
    test_register_read();
    test_address_extremes();
    test_half_period_zero();
    test_address_retry();
    test_retry_exhausted();
    test_retry_unbounded();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();
    test_long_half_period();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_i2c_register_access_master_unit passed");
    end else begin
      $display("tb_i2c_register_access_master_unit failed");
    end
    $finish;
  end

endmodule
